[rtl/tlssni_pkg.sv]
// Shared types and constants of the ClientHello server name extractor.
`default_nettype none

package tlssni_pkg;

	// Fixed message layout constants.
	localparam int MIN_HELLO_LEN   = 43;
	localparam int SID_LEN_OFFSET  = 34;
	localparam int SNI_MIN_EXT_LEN = 5;
	localparam int EXT_HDR_LEN     = 4;

	// Parse phases of the ClientHello body.
	typedef enum logic [3:0] {
		PH_FIXED  = 4'd0,
		PH_CS_HI  = 4'd1,
		PH_CS_LO  = 4'd2,
		PH_CM_LEN = 4'd3,
		PH_EXS_HI = 4'd4,
		PH_EXS_LO = 4'd5,
		PH_ET0    = 4'd6,
		PH_ET1    = 4'd7,
		PH_EL0    = 4'd8,
		PH_EL1    = 4'd9,
		PH_SNT    = 4'd10,
		PH_NL0    = 4'd11,
		PH_NL1    = 4'd12,
		PH_NAME   = 4'd13,
		PH_STOP   = 4'd14
	} phase_t;

	// One result word as produced by the parser.
	typedef struct packed {
		logic       present;
		logic [7:0] name_byte;
		logic       name_valid;
		logic       done_res;
		logic       found;
		logic [7:0] name_length;
	} result_t;

endpackage

`default_nettype wire

[rtl/tlssni_parser.sv]
// Byte-wise ClientHello parser: position tracking, field walk and name streaming.
`default_nettype none

module tlssni_parser
	import tlssni_pkg::*;
#(
	parameter int POS_BITS = 17
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_data,
	input  wire logic       in_last,
	input  wire logic [7:0] max_name_bytes,
	output result_t         result
);

	localparam int SUM_W = ((POS_BITS > 16) ? POS_BITS : 16) + 1;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	logic [POS_BITS-1:0] pos_q, ext_total_end_q, cur_ext_end_q, name_end_q;
	logic [POS_BITS-1:0] pos_upd, ext_total_end_upd, cur_ext_end_upd, name_end_upd;
	phase_t              phase_q, phase_upd;
	logic [15:0]         skip_q, skip_upd;
	logic [15:0]         shift_q, shift_upd;
	logic [7:0]          emitted_q, emitted_upd;
	logic                complete_q, complete_upd;

	logic                at_max, skipping, acting, nv;
	logic [15:0]         len16;
	logic [SUM_W-1:0]    p1, len_sum, hdr_end, rest_diff;
	logic [POS_BITS-1:0] len_end_sat;

	// Shared position arithmetic.
	assign at_max      = (pos_q == POS_MAX);
	assign skipping    = (phase_q < PH_STOP) && (skip_q != 16'd0);
	assign acting      = !at_max && !skipping;
	assign len16       = {shift_q[7:0], in_data};
	assign p1          = SUM_W'(pos_q) + SUM_W'(1);
	assign len_sum     = p1 + SUM_W'(len16);
	assign len_end_sat = (len_sum > SUM_W'(POS_MAX)) ? POS_MAX : len_sum[POS_BITS-1:0];
	assign hdr_end     = SUM_W'(pos_q) + SUM_W'(EXT_HDR_LEN);
	assign rest_diff   = SUM_W'(cur_ext_end_q) - p1;

	// Name byte emission.
	always_comb begin
		nv = in_valid && acting && (phase_q == PH_NAME) && (emitted_q < max_name_bytes);
	end

	// Next-state of the parse.
	always_comb begin
		phase_upd         = phase_q;
		skip_upd          = skip_q;
		shift_upd         = shift_q;
		ext_total_end_upd = ext_total_end_q;
		cur_ext_end_upd   = cur_ext_end_q;
		name_end_upd      = name_end_q;
		complete_upd      = complete_q;
		emitted_upd       = nv ? emitted_q + 8'd1 : emitted_q;
		pos_upd           = at_max ? POS_MAX : pos_q + POS_BITS'(1);
		if (at_max) begin
			phase_upd = PH_STOP;
		end else if (skipping) begin
			skip_upd = skip_q - 16'd1;
		end else begin
			unique case (phase_q)
				PH_FIXED: begin
					if (pos_q == POS_BITS'(SID_LEN_OFFSET)) begin
						skip_upd  = {8'd0, in_data};
						phase_upd = PH_CS_HI;
					end
				end
				PH_CS_HI: begin
					shift_upd = {8'd0, in_data};
					phase_upd = PH_CS_LO;
				end
				PH_CS_LO: begin
					skip_upd  = len16;
					phase_upd = PH_CM_LEN;
				end
				PH_CM_LEN: begin
					skip_upd  = {8'd0, in_data};
					phase_upd = PH_EXS_HI;
				end
				PH_EXS_HI: begin
					shift_upd = {8'd0, in_data};
					phase_upd = PH_EXS_LO;
				end
				PH_EXS_LO: begin
					ext_total_end_upd = len_end_sat;
					phase_upd         = PH_ET0;
				end
				PH_ET0: begin
					if (hdr_end > SUM_W'(ext_total_end_q)) begin
						phase_upd = PH_STOP;
					end else begin
						shift_upd = {8'd0, in_data};
						phase_upd = PH_ET1;
					end
				end
				PH_ET1: begin
					shift_upd = {shift_q[7:0], in_data};
					phase_upd = PH_EL0;
				end
				PH_EL0: begin
					shift_upd = {7'd0, (shift_q == 16'd0), in_data};
					phase_upd = PH_EL1;
				end
				PH_EL1: begin
					cur_ext_end_upd = len_end_sat;
					if (shift_q[8] && (len16 > 16'(SNI_MIN_EXT_LEN))) begin
						// Skip the server name list length.
						skip_upd  = 16'd2;
						phase_upd = PH_SNT;
					end else begin
						skip_upd  = len16;
						phase_upd = PH_ET0;
					end
				end
				PH_SNT: begin
					shift_upd = {7'd0, (in_data == 8'd0), 8'd0};
					phase_upd = PH_NL0;
				end
				PH_NL0: begin
					shift_upd = {7'd0, shift_q[8], in_data};
					phase_upd = PH_NL1;
				end
				PH_NL1: begin
					if (shift_q[8] && (len16 != 16'd0) && (len_end_sat <= cur_ext_end_q)) begin
						name_end_upd = len_end_sat;
						phase_upd    = PH_NAME;
					end else begin
						// Rejected entry: skip the rest of this extension.
						skip_upd  = (SUM_W'(cur_ext_end_q) > p1) ? rest_diff[15:0] : 16'd0;
						phase_upd = PH_ET0;
					end
				end
				PH_NAME: begin
					if (p1 >= SUM_W'(name_end_q)) begin
						complete_upd = 1'b1;
						phase_upd    = PH_STOP;
					end
				end
				default: begin
					phase_upd = PH_STOP;
				end
			endcase
		end
	end

	// Result word for the accepted byte.
	always_comb begin
		result.present     = in_valid && (nv || in_last);
		result.name_byte   = nv ? in_data : 8'd0;
		result.name_valid  = nv;
		result.done_res    = in_last;
		result.found       = 1'b0;
		result.name_length = 8'd0;
		if (in_last) begin
			result.found = (pos_q >= POS_BITS'(MIN_HELLO_LEN - 1)) && !at_max
				&& complete_upd && (SUM_W'(cur_ext_end_upd) <= p1);
			result.name_length = emitted_upd;
		end
	end

	// Parse state registers; the last byte starts a fresh message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= '0;
			phase_q         <= PH_FIXED;
			skip_q          <= '0;
			shift_q         <= '0;
			ext_total_end_q <= '0;
			cur_ext_end_q   <= '0;
			name_end_q      <= '0;
			emitted_q       <= '0;
			complete_q      <= 1'b0;
		end else if (in_valid) begin
			if (in_last) begin
				pos_q           <= '0;
				phase_q         <= PH_FIXED;
				skip_q          <= '0;
				shift_q         <= '0;
				ext_total_end_q <= '0;
				cur_ext_end_q   <= '0;
				name_end_q      <= '0;
				emitted_q       <= '0;
				complete_q      <= 1'b0;
			end else begin
				pos_q           <= pos_upd;
				phase_q         <= phase_upd;
				skip_q          <= skip_upd;
				shift_q         <= shift_upd;
				ext_total_end_q <= ext_total_end_upd;
				cur_ext_end_q   <= cur_ext_end_upd;
				name_end_q      <= name_end_upd;
				emitted_q       <= emitted_upd;
				complete_q      <= complete_upd;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/tls_client_hello_sni_extractor.sv]
// Top level of the ClientHello server name extractor with output buffering.
//
// Channel   Dir  Word contents
// s_*       in   tdata[7:0] data_byte, tlast is_last
// m_*       out  tdata[7:0] name_byte, tdata[15:8] name_length,
//                tuser[0] name_valid, tuser[1] found, tlast done_res
// cfg_*     in   cfg_wdata = max_name_bytes, written when cfg_we is high
//
// One input word is taken per cycle while the skid entry is empty; its result is
// registered in the output buffer. The parse state updates from each accepted byte.
// A two-entry output buffer (register plus skid) keeps s_tready independent of m_tready.
// Reset clears the parse, empties the buffer and sets max_name_bytes to 255.
`default_nettype none

module tls_client_hello_sni_extractor
	import tlssni_pkg::*;
#(
	parameter int POS_BITS = 17
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] name_byte, [15:8] name_length
	output logic [1:0]       m_tuser,   // [0] name_valid, [1] found
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	logic [7:0] max_bytes_q;
	logic       accept, push, out_free;
	result_t    res, out_q, skid_q;
	logic       out_v_q, skid_v_q;

	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;
	assign push     = res.present;
	assign out_free = !out_v_q || m_tready;

	// Name length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= 8'd255;
		end else if (cfg_we) begin
			max_bytes_q <= cfg_wdata;
		end
	end

	tlssni_parser #(
		.POS_BITS(POS_BITS)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (accept),
		.in_data       (s_tdata),
		.in_last       (s_tlast),
		.max_name_bytes(max_bytes_q),
		.result        (res)
	);

	// Output register with skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload of the buffer entries.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.name_length, out_q.name_byte};
	assign m_tuser  = {out_q.found, out_q.name_valid};
	assign m_tlast  = out_q.done_res;

endmodule

`default_nettype wire
